[sv/grnc_pkg.sv]
// Package: types, constants and codes shared by the ring cell lister.
`default_nettype none
package grnc_pkg;

	localparam int CELL_SIZE_DEF = 32;
	localparam int MAX_RING_DEF  = 3;
	localparam int MAX_GRID_DEF  = 64;

	localparam int COORD_W  = 6;
	localparam int RADIUS_W = 12;
	localparam int EXTENT_W = 7;
	// signed working width for center +/- ring offset
	localparam int SCOORD_W = 8;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = EXTENT_W;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

	localparam logic [EXTENT_W-1:0] GRID_WIDTH_RST  = 7'd16;
	localparam logic [EXTENT_W-1:0] GRID_HEIGHT_RST = 7'd16;

	typedef struct packed {
		logic [COORD_W-1:0]  center_x;
		logic [COORD_W-1:0]  center_y;
		logic [RADIUS_W-1:0] radius;
	} req_t;

	typedef struct packed {
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic               last;
	} cell_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		SIDE_RIGHT,
		SIDE_LEFT,
		SIDE_TOP,
		SIDE_BOTTOM
	} side_t;

	typedef struct packed {
		logic load;
		logic step;
		logic flush;
	} cmd_t;

	typedef struct packed {
		logic cand_valid;
		logic cand_last;
		logic hold_full;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[sv/grid_ring_neighbour_cells.sv]
// Top level: ring-ordered neighbour cell lister with grid size registers.
//
// Usage: a request (center_x, center_y, radius) is a transfer on req_valid /
// req_stall / req_data. The block answers with a run of cell transfers on
// cell_valid / cell_stall / cell_data: the center cell first, then each ring
// outward (right column, left column, top row, bottom row), skipping ring cells
// outside the grid. The final cell of a request has last set.
// grid_width / grid_height are written through cfg_we, cfg_idx, cfg_wdata
// while the block is idle; other writes are not guarded.
// Timing: the scanner visits one candidate position per cycle while a stalled
// output does not hold it back, and a request holds the input side until
// every position of its R rings (R the ring count) has been scanned and the
// last cell flushed. A finished last cell may wait in the output register
// while the next request is taken.
// Reset clears the controller, the hold and output valid, and sets both
// grid registers to 16. A stalled output holds its cell and pauses the scanner at
// the next in-grid cell once the hold stage is also full.
`default_nettype none
module grid_ring_neighbour_cells
	import grnc_pkg::*;
#(
	parameter int CELL_SIZE = CELL_SIZE_DEF,
	parameter int MAX_RING  = MAX_RING_DEF,
	parameter int MAX_GRID  = MAX_GRID_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire req_t                  req_data,
	output logic                       cell_valid,
	input  wire logic                  cell_stall,
	output cell_t                      cell_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [EXTENT_W-1:0] grid_width_q;
	logic [EXTENT_W-1:0] grid_height_q;
	cmd_t                cmd;
	sts_t                sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_GRID_WIDTH:  grid_width_q  <= cfg_wdata;
				REG_GRID_HEIGHT: grid_height_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	grnc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	grnc_dp #(
		.CELL_SIZE (CELL_SIZE),
		.MAX_RING  (MAX_RING),
		.MAX_GRID  (MAX_GRID)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_data    (req_data),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.cmd         (cmd),
		.sts         (sts),
		.cell_valid  (cell_valid),
		.cell_stall  (cell_stall),
		.cell_data   (cell_data)
	);

endmodule
`default_nettype wire

[sv/grnc_ctrl.sv]
// Controller: sequences load, scan and final flush of one request.
`default_nettype none
module grnc_ctrl
	import grnc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// a valid candidate with a full hold needs a free output slot
				if (!(sts.cand_valid && sts.hold_full && !sts.out_free)) begin
					cmd.step = 1'b1;
					if (sts.cand_last) begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_flush_has_cell: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> sts.hold_full)
		else $error("flush state with empty hold");

	a_idle_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !sts.hold_full)
		else $error("hold still full while idle");

endmodule
`default_nettype wire

[sv/grnc_dp.sv]
// Datapath: ring scanner, bounds check, hold stage and output register.
`default_nettype none
module grnc_dp
	import grnc_pkg::*;
#(
	parameter int CELL_SIZE = CELL_SIZE_DEF,
	parameter int MAX_RING  = MAX_RING_DEF,
	parameter int MAX_GRID  = MAX_GRID_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire req_t                req_data,
	input  wire logic [EXTENT_W-1:0] grid_width,
	input  wire logic [EXTENT_W-1:0] grid_height,
	input  wire cmd_t                cmd,
	output sts_t                     sts,
	output logic                     cell_valid,
	input  wire logic                cell_stall,
	output cell_t                    cell_data
);

	localparam int RING_W  = $clog2(MAX_RING + 1);
	localparam int IW      = RING_W + 1;
	localparam int EXT_CAP = (MAX_GRID < 64) ? MAX_GRID : 64;
	localparam int NUM_W   = $clog2(2 * ((1 << RADIUS_W) - 1) + CELL_SIZE + 1);
	localparam logic signed [IW-1:0] I_ONE = 1;

	logic [COORD_W-1:0]   cx_q;
	logic [COORD_W-1:0]   cy_q;
	logic [RING_W-1:0]    rings_q;
	logic [RING_W-1:0]    r_q;
	side_t                side_q;
	logic signed [IW-1:0] i_q;
	logic                 centre_q;

	logic [COORD_W-1:0] hold_x_q;
	logic [COORD_W-1:0] hold_y_q;
	logic               hold_full_q;

	cell_t out_q;
	logic  out_valid_q;

	logic [NUM_W-1:0]        num;
	logic [RING_W-1:0]       ring_cnt;
	logic [EXTENT_W-1:0]     w_eff;
	logic [EXTENT_W-1:0]     h_eff;
	logic signed [SCOORD_W-1:0] cx_s;
	logic signed [SCOORD_W-1:0] cy_s;
	logic signed [SCOORD_W-1:0] r_c;
	logic signed [SCOORD_W-1:0] i_c;
	logic signed [SCOORD_W-1:0] cand_x;
	logic signed [SCOORD_W-1:0] cand_y;
	logic signed [IW-1:0]       r_s;
	logic                       x_ok;
	logic                       y_ok;
	logic                       cand_valid;
	logic                       end_side;
	logic                       cand_last;
	logic                       out_free;
	logic                       move;

	// ring count: floor((2*radius + CELL) / (2*CELL)) + 1, saturated
	always_comb begin
		num      = NUM_W'({req_data.radius, 1'b0}) + NUM_W'(CELL_SIZE);
		ring_cnt = RING_W'(1);
		for (int k = 1; k < MAX_RING; k++) begin
			if (num >= NUM_W'(2 * k * CELL_SIZE)) begin
				ring_cnt = RING_W'(k + 1);
			end
		end
	end

	assign w_eff = (grid_width > EXTENT_W'(EXT_CAP)) ? EXTENT_W'(EXT_CAP) : grid_width;
	assign h_eff = (grid_height > EXTENT_W'(EXT_CAP)) ? EXTENT_W'(EXT_CAP) : grid_height;

	assign r_s  = signed'({1'b0, r_q});
	assign cx_s = signed'({{(SCOORD_W - COORD_W){1'b0}}, cx_q});
	assign cy_s = signed'({{(SCOORD_W - COORD_W){1'b0}}, cy_q});
	assign r_c  = signed'({{(SCOORD_W - RING_W){1'b0}}, r_q});
	assign i_c  = signed'({{(SCOORD_W - IW){i_q[IW-1]}}, i_q});

	always_comb begin
		cand_x = cx_s;
		cand_y = cy_s;
		case (side_q)
			SIDE_RIGHT: begin
				cand_x = cx_s + r_c;
				cand_y = cy_s + i_c;
			end
			SIDE_LEFT: begin
				cand_x = cx_s - r_c;
				cand_y = cy_s + i_c;
			end
			SIDE_TOP: begin
				cand_x = cx_s + i_c;
				cand_y = cy_s + r_c;
			end
			SIDE_BOTTOM: begin
				cand_x = cx_s + i_c;
				cand_y = cy_s - r_c;
			end
			default: begin
				cand_x = cx_s;
				cand_y = cy_s;
			end
		endcase
		if (centre_q) begin
			cand_x = cx_s;
			cand_y = cy_s;
		end
	end

	assign x_ok       = !cand_x[SCOORD_W-1] && (cand_x[EXTENT_W-1:0] < w_eff);
	assign y_ok       = !cand_y[SCOORD_W-1] && (cand_y[EXTENT_W-1:0] < h_eff);
	assign cand_valid = centre_q || (x_ok && y_ok);

	assign end_side  = (side_q == SIDE_RIGHT || side_q == SIDE_LEFT) ? (i_q == r_s)
	                                                                : (i_q == r_s - I_ONE);
	assign cand_last = !centre_q && (side_q == SIDE_BOTTOM) && end_side && (r_q == rings_q);

	assign out_free = !out_valid_q || !cell_stall;
	assign move     = (cmd.step && cand_valid && hold_full_q) || cmd.flush;

	assign sts.cand_valid = cand_valid;
	assign sts.cand_last  = cand_last;
	assign sts.hold_full  = hold_full_q;
	assign sts.out_free   = out_free;

	// scanner position
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cx_q     <= req_data.center_x;
			cy_q     <= req_data.center_y;
			rings_q  <= ring_cnt;
			r_q      <= RING_W'(1);
			side_q   <= SIDE_RIGHT;
			i_q      <= -I_ONE;
			centre_q <= 1'b1;
		end else if (cmd.step) begin
			if (centre_q) begin
				centre_q <= 1'b0;
			end else if (end_side) begin
				case (side_q)
					SIDE_RIGHT: begin
						side_q <= SIDE_LEFT;
						i_q    <= -r_s;
					end
					SIDE_LEFT: begin
						side_q <= SIDE_TOP;
						i_q    <= I_ONE - r_s;
					end
					SIDE_TOP: begin
						side_q <= SIDE_BOTTOM;
						i_q    <= I_ONE - r_s;
					end
					default: begin
						side_q <= SIDE_RIGHT;
						r_q    <= r_q + RING_W'(1);
						i_q    <= -(r_s + I_ONE);
					end
				endcase
			end else begin
				i_q <= i_q + I_ONE;
			end
		end
	end

	// one-cell hold so the final cell can be flagged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_full_q <= 1'b0;
		end else if (cmd.load || cmd.flush) begin
			hold_full_q <= 1'b0;
		end else if (cmd.step && cand_valid) begin
			hold_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && cand_valid) begin
			hold_x_q <= cand_x[COORD_W-1:0];
			hold_y_q <= cand_y[COORD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (!cell_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q.cell_x <= hold_x_q;
			out_q.cell_y <= hold_y_q;
			out_q.last   <= cmd.flush;
		end
	end

	assign cell_valid = out_valid_q;
	assign cell_data  = out_q;

	a_flush_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> hold_full_q)
		else $error("flush with no held cell");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		move |-> (!out_valid_q || !cell_stall))
		else $error("output register overwritten while stalled");

	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && !centre_q) |-> (r_q != '0 && r_q <= rings_q))
		else $error("ring index out of bounds");

endmodule
`default_nettype wire
